// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file gdr_chk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on a clock, switched off while reset is high
`define GDR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gdr assertion failed");

// Condition that must never be seen
`define GDR_ASSERT_NEVER(label, clk, rst, cond) \
   `GDR_ASSERT(label, clk, rst, !(cond))

`endif

// ===== rtl/gdr_pkg.sv =====
// ----------------------------------------------------------------------------
// gdr_pkg
// Types and constants for the depth-first reachability block.
// ----------------------------------------------------------------------------
package gdr_pkg;

   localparam int NODES_DEFAULT = 16;
   localparam int NODE_W        = 4;
   localparam int MAX_RESULTS   = 16;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_WALK  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [NODE_W-1:0] first_node;
      logic [NODE_W-1:0] second_node;
   } gdr_req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              last;
   } gdr_rsp_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic add_rd_a;
      logic add_wr_a;
      logic add_rd_b;
      logic add_wr_b;
      logic walk_start;
      logic walk_step;
      logic walk_pop;
   } gdr_cmd_type;

   typedef struct packed {
      logic a_ok;
      logic b_ok;
      logic found;
      logic depth_one;
   } gdr_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR_A,
      ST_ADD_RD_B,
      ST_ADD_WR_B,
      ST_WALK_EVAL,
      ST_WALK_POP
   } gdr_state_type;

endpackage

// ===== rtl/gdr_ram.sv =====
// ----------------------------------------------------------------------------
// gdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdr_ctrl
// Sequencer for edge insertion, clearing and the depth-first walk.
// ----------------------------------------------------------------------------
module gdr_ctrl
   import gdr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [1:0]     req_kind,
   input  gdr_status_type status,
   output logic           busy,
   output gdr_cmd_type    cmd
);

   gdr_state_type state_ff;
   gdr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_kind)
                  KIND_ADD: begin
                     if (status.a_ok && status.b_ok) begin
                        cmd.add_rd_a = 1'b1;
                        state_in     = ST_ADD_WR_A;
                     end
                  end
                  KIND_WALK: begin
                     if (status.a_ok) begin
                        cmd.walk_start = 1'b1;
                        state_in       = ST_WALK_EVAL;
                     end
                  end
                  KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD_WR_A: begin
            cmd.add_wr_a = 1'b1;
            state_in     = ST_ADD_RD_B;
         end
         ST_ADD_RD_B: begin
            cmd.add_rd_b = 1'b1;
            state_in     = ST_ADD_WR_B;
         end
         ST_ADD_WR_B: begin
            cmd.add_wr_b = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_WALK_EVAL: begin
            cmd.walk_step = 1'b1;
            if (!status.found) begin
               // top has no open neighbour: pop, or finish on the last entry
               state_in = status.depth_one ? ST_IDLE : ST_WALK_POP;
            end
         end
         ST_WALK_POP: begin
            cmd.walk_pop = 1'b1;
            state_in     = ST_WALK_EVAL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/gdr_dp.sv =====
// ----------------------------------------------------------------------------
// gdr_dp
// Datapath: adjacency RAM with row valid bits, walk stack RAM, visited mask,
// lowest-open-neighbour search and the result register.
// ----------------------------------------------------------------------------
module gdr_dp
   import gdr_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  gdr_req_type    req_data,
   input  gdr_cmd_type    cmd,
   output gdr_status_type status,
   output logic           rsp_valid,
   output gdr_rsp_type    rsp_data
);

   localparam int IDX_W   = $clog2(NODES);
   localparam int DEPTH_W = $clog2(NODES + 1);
   localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int EXT_W   = IDX_W + NODE_W;

   // latched edge endpoints
   logic [NODE_W-1:0]  a_ff, b_ff;
   // control state
   logic [NODES-1:0]   rowvalid_ff, rowvalid_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [NODES-1:0]   visited_ff, visited_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   // payload
   logic [IDX_W-1:0]   top_ff, top_in;
   logic [IDX_W-1:0]   pend_ff, pend_in;
   gdr_rsp_type        rsp_ff, rsp_in;

   logic [EXT_W-1:0]   live_a_ext, live_b_ext, a_ext, b_ext, pend_ext;
   logic [IDX_W-1:0]   live_a, a_idx, b_idx;

   logic [NODES-1:0]   adj_rd_data, adj_wr_data, row, open, iso;
   logic [IDX_W-1:0]   adj_rd_addr, adj_wr_addr, low_idx;
   logic               adj_wr_en;
   logic [IDX_W-1:0]   stk_rd_data, stk_wr_addr, stk_wr_data, stk_rd_addr;
   logic               stk_wr_en;
   logic [DEPTH_W-1:0] depth_m2;
   logic               found, push_ok, count_ok;

   assign live_a_ext = {{IDX_W{1'b0}}, req_data.first_node};
   assign live_b_ext = {{IDX_W{1'b0}}, req_data.second_node};
   assign a_ext      = {{IDX_W{1'b0}}, a_ff};
   assign b_ext      = {{IDX_W{1'b0}}, b_ff};
   assign pend_ext   = {{NODE_W{1'b0}}, pend_ff};
   assign live_a     = live_a_ext[IDX_W-1:0];
   assign a_idx      = a_ext[IDX_W-1:0];
   assign b_idx      = b_ext[IDX_W-1:0];

   // a row never written since reset or clear reads as empty
   assign row  = rd_valid_ff ? adj_rd_data : '0;
   assign open = row & ~visited_ff;
   assign iso  = open & (~open + NODES'(1));
   assign found = |open;

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < NODES; i++) begin
         if (iso[i]) begin
            low_idx = low_idx | IDX_W'(i);
         end
      end
   end

   assign push_ok  = depth_ff < DEPTH_W'(NODES);
   assign count_ok = count_ff < CNT_W'(MAX_RESULTS);
   assign depth_m2 = depth_ff - DEPTH_W'(2);

   assign status.a_ok      = live_a_ext < EXT_W'(NODES);
   assign status.b_ok      = live_b_ext < EXT_W'(NODES);
   assign status.found     = found;
   assign status.depth_one = depth_ff == DEPTH_W'(1);

   // adjacency RAM port control
   always_comb begin
      adj_rd_addr = top_ff;
      adj_wr_en   = 1'b0;
      adj_wr_addr = a_idx;
      adj_wr_data = row | (NODES'(1) << b_idx);
      if (cmd.add_rd_a || cmd.walk_start) begin
         adj_rd_addr = live_a;
      end
      if (cmd.add_wr_a) begin
         adj_wr_en = 1'b1;
      end
      if (cmd.add_rd_b) begin
         adj_rd_addr = b_idx;
      end
      if (cmd.add_wr_b) begin
         adj_wr_en   = 1'b1;
         adj_wr_addr = b_idx;
         adj_wr_data = row | (NODES'(1) << a_idx);
      end
      if (cmd.walk_step && found && push_ok) begin
         adj_rd_addr = low_idx;
      end
      if (cmd.walk_pop) begin
         adj_rd_addr = stk_rd_data;
      end
   end

   assign stk_wr_en   = cmd.walk_start || (cmd.walk_step && found && push_ok);
   assign stk_wr_addr = cmd.walk_start ? '0 : depth_ff[IDX_W-1:0];
   assign stk_wr_data = cmd.walk_start ? live_a : low_idx;
   assign stk_rd_addr = depth_m2[IDX_W-1:0];

   always_comb begin
      rowvalid_in  = rowvalid_ff;
      rd_valid_in  = rowvalid_ff[adj_rd_addr];
      visited_in   = visited_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      top_in       = top_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;

      if (cmd.clear) begin
         rowvalid_in = '0;
      end
      if (cmd.add_wr_a) begin
         rowvalid_in[a_idx] = 1'b1;
      end
      if (cmd.add_wr_b) begin
         rowvalid_in[b_idx] = 1'b1;
      end

      if (cmd.walk_start) begin
         visited_in = NODES'(1) << live_a;
         depth_in   = DEPTH_W'(1);
         count_in   = CNT_W'(1);
         top_in     = live_a;
         pend_in    = live_a;
      end

      // results go out one behind, so the final one can carry last
      if (cmd.walk_step) begin
         if (found) begin
            visited_in = visited_ff | (NODES'(1) << low_idx);
            if (push_ok) begin
               depth_in = depth_ff + DEPTH_W'(1);
               top_in   = low_idx;
            end
            if (count_ok) begin
               rsp_valid_in = 1'b1;
               rsp_in.node  = pend_ext[NODE_W-1:0];
               rsp_in.last  = 1'b0;
               pend_in      = low_idx;
               count_in     = count_ff + CNT_W'(1);
            end
         end else if (status.depth_one) begin
            rsp_valid_in = 1'b1;
            rsp_in.node  = pend_ext[NODE_W-1:0];
            rsp_in.last  = 1'b1;
            depth_in     = '0;
         end else begin
            depth_in = depth_ff - DEPTH_W'(1);
         end
      end

      if (cmd.walk_pop) begin
         top_in = stk_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rowvalid_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         visited_ff   <= '0;
         depth_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rowvalid_ff  <= rowvalid_in;
         rd_valid_ff  <= rd_valid_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= req_data.first_node;
         b_ff <= req_data.second_node;
      end
      top_ff  <= top_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   gdr_ram #(
      .WIDTH (NODES),
      .DEPTH (NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   gdr_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NODES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/graph_dfs_reachability.sv =====
// Add edge: read-modify-write of both rows (busy: wr A, rd B, wr B); clear: no busy.
// A walk takes one search step per push and per pop, plus a stack RAM read
// per pop; results are registered and appear in the cycle after their step.
// Results cannot be stalled; rsp_valid strobes each for exactly one cycle.
// Synchronous reset empties the graph at once via per-row valid bits.
// ----------------------------------------------------------------------------
// graph_dfs_reachability
// Depth-first reachability over a bit adjacency matrix, preorder output.
// ----------------------------------------------------------------------------
module graph_dfs_reachability
   import gdr_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  gdr_req_type req_data,
   output logic        rsp_valid,
   output gdr_rsp_type rsp_data
);

   gdr_cmd_type    cmd;
   gdr_status_type status;

   gdr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.kind),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   gdr_dp #(
      .NODES (NODES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/gdr_chk.sv =====
// ----------------------------------------------------------------------------
// gdr_chk
// Port-level checks on the reachability block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdr_chk
   import gdr_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input gdr_req_type req_data,
   input logic        rsp_valid,
   input gdr_rsp_type rsp_data
);

   logic take, in_a, in_b;

   assign take = start && !busy;
   assign in_a = int'(req_data.first_node) < NODES;
   assign in_b = int'(req_data.second_node) < NODES;

   `GDR_ASSERT(a_add_busy, clock, reset, (take && req_data.kind == KIND_ADD && in_a && in_b) |=> busy)
   `GDR_ASSERT(a_walk_busy, clock, reset, (take && req_data.kind == KIND_WALK && in_a) |=> busy)
   `GDR_ASSERT(a_rsp_in_walk, clock, reset, rsp_valid |-> $past(busy))
   `GDR_ASSERT_NEVER(a_gap_after_last, clock, reset, $past(rsp_valid && rsp_data.last) && rsp_valid)

endmodule

bind graph_dfs_reachability gdr_chk #(
   .NODES (NODES)
) u_gdr_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_graph_dfs_reachability.sv =====
// ----------------------------------------------------------------------------
// tb_graph_dfs_reachability
// Self-checking bench for the depth-first reachability block. Edge, clear and
// walk items are pushed through the start/busy handshake. A scoreboard keeps
// its own copy of the adjacency matrix and works out the preorder for every
// walk. Each strobed vertex is checked against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_graph_dfs_reachability;
   import gdr_pkg::*;

   localparam int          VERTICES     = NODES_DEFAULT;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam int          DRAIN_CYCLES = 64;

   class reach_scoreboard;
      logic [VERTICES-1:0] adj_rows [VERTICES];
      gdr_rsp_type         pending_vertices [$];
      int unsigned         errors;

      function new();
         foreach (adj_rows[i]) adj_rows[i] = '0;
         errors = 0;
      endfunction

      // Preorder of the walk from root, lowest unvisited neighbour first
      function void predict_preorder(logic [NODE_W-1:0] root);
         logic [VERTICES-1:0] seen;
         logic [VERTICES-1:0] open;
         logic [NODE_W-1:0]   path [VERTICES];
         int                  depth;
         int                  nxt;
         gdr_rsp_type         walk [$];
         gdr_rsp_type         v;
         seen       = '0;
         seen[root] = 1'b1;
         path[0]    = root;
         depth      = 1;
         v.node     = root;
         v.last     = 1'b0;
         walk       = {walk, v};
         while (depth > 0) begin
            open = adj_rows[path[depth-1]] & ~seen;
            if (open == '0) begin
               depth--;
            end else begin
               nxt = 0;
               while (!open[nxt]) nxt++;
               seen[nxt] = 1'b1;
               if (depth < VERTICES) begin
                  path[depth] = NODE_W'(nxt);
                  depth++;
               end
               v.node = NODE_W'(nxt);
               v.last = 1'b0;
               walk   = {walk, v};
            end
         end
         walk[walk.size()-1].last = 1'b1;
         pending_vertices = {pending_vertices, walk};
      endfunction

      function void note_item(gdr_req_type item);
         case (item.kind)
            KIND_ADD: begin
               adj_rows[item.first_node][item.second_node] = 1'b1;
               adj_rows[item.second_node][item.first_node] = 1'b1;
            end
            KIND_CLEAR: begin
               foreach (adj_rows[i]) adj_rows[i] = '0;
            end
            KIND_WALK: predict_preorder(item.first_node);
            default: ;
         endcase
      endfunction

      function void check_vertex(gdr_rsp_type got);
         gdr_rsp_type want;
         if (pending_vertices.size() == 0) begin
            $error("vertex %0d (last %0b) with none expected", got.node, got.last);
            errors++;
            return;
         end
         want = pending_vertices.pop_front();
         if (got.node !== want.node) begin
            $error("node: expected %0d, got %0d", want.node, got.node);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   gdr_req_type req_data;
   logic        rsp_valid;
   gdr_rsp_type rsp_data;

   reach_scoreboard sb = new();
   int idle_pct;
   int sent_count;

   graph_dfs_reachability #(
      .NODES(VERTICES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Results are checked before the item taken at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_vertex(rsp_data);
         if (start && !busy) sb.note_item(req_data);
      end
   end

   task automatic send_item(input logic [1:0] kind, input int a, input int b);
      gdr_req_type item;
      item.kind        = kind;
      item.first_node  = a[NODE_W-1:0];
      item.second_node = b[NODE_W-1:0];
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      if (kind != KIND_UNUSED) sent_count++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.pending_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_edge(input int a, input int b);
      if ($urandom_range(1)) send_item(KIND_ADD, a, b);
      else send_item(KIND_ADD, b, a);
   endtask

   // Graphs are mostly paths or trees so that walks reach far and stack deep
   task automatic run_phase(input int pct, input int quota);
      int base;
      int choice;
      int perm [VERTICES];
      int j;
      int tmp;
      idle_pct = pct;
      base     = sent_count;
      while (sent_count - base < quota) begin
         if ($urandom_range(99) < 50) send_item(KIND_CLEAR, $urandom_range(15), $urandom_range(15));
         choice = $urandom_range(99);
         if (choice < 30) begin
            foreach (perm[i]) perm[i] = i;
            for (int i = VERTICES - 1; i > 0; i--) begin
               j       = $urandom_range(i);
               tmp     = perm[i];
               perm[i] = perm[j];
               perm[j] = tmp;
            end
            for (int i = 0; i < VERTICES - 1; i++) add_edge(perm[i], perm[i+1]);
            send_item(KIND_WALK, perm[0], $urandom_range(15));
         end else if (choice < 55) begin
            for (int i = 1; i < VERTICES; i++) add_edge(i, $urandom_range(i - 1));
         end else if (choice < 90) begin
            repeat ($urandom_range(1, 8)) add_edge($urandom_range(15), $urandom_range(15));
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(2'($urandom_range(3)), $urandom_range(15), $urandom_range(15));
         end
         if ($urandom_range(99) < 20)
            send_item(KIND_UNUSED, $urandom_range(15), $urandom_range(15));
         repeat ($urandom_range(1, 3))
            send_item(KIND_WALK, $urandom_range(15), $urandom_range(15));
      end
   endtask

   initial begin
      reset      <= 1'b1;
      start      <= 1'b0;
      req_data   <= '0;
      idle_pct    = 0;
      sent_count  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty graph, extremes, self loop, unused kind, clear
      send_item(KIND_WALK, 0, 15);
      send_item(KIND_WALK, 15, 0);
      send_item(KIND_ADD, 0, 15);
      send_item(KIND_ADD, 5, 5);
      send_item(KIND_ADD, 15, 3);
      send_item(KIND_ADD, 3, 7);
      send_item(KIND_UNUSED, 7, 0);
      send_item(KIND_WALK, 0, 0);
      send_item(KIND_WALK, 7, 15);
      send_item(KIND_WALK, 5, 5);
      send_item(KIND_ADD, 15, 15);
      send_item(KIND_ADD, 1, 0);
      send_item(KIND_WALK, 15, 15);
      send_item(KIND_CLEAR, 15, 15);
      send_item(KIND_WALK, 15, 0);
      send_item(KIND_UNUSED, 15, 15);
      send_item(KIND_WALK, 3, 0);
      send_item(KIND_ADD, 14, 15);
      send_item(KIND_WALK, 14, 15);
      wait_drained();

      run_phase(11, 50);
      wait_drained();
      run_phase(69, 50);
      wait_drained();
      run_phase(0, 50);
      wait_drained();

      if (sb.pending_vertices.size() != 0) begin
         $error("%0d expected vertices never arrived", sb.pending_vertices.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
